// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is asserted
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication, also checked across reset
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/lr_pkg.sv -----
// ----------------------------------------------------------------------------
// lr_pkg
// shared types and constants of the line rasterizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lr_pkg;

    // item mode codes
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    // decision value carries this many bits above the coordinate width
    localparam int DEC_EXTRA_BITS = 3;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// ----- sv/lr_fifo.sv -----
// ----------------------------------------------------------------------------
// lr_fifo
// small first-word-fall-through queue built from registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [WIDTH-1:0]       i_data,
    input  logic                   i_pop,
    output logic [WIDTH-1:0]       o_data,
    output lr_pkg::t_fifo_stat     o_stat
);
    import lr_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CNT_BITS'(i_push) - CNT_BITS'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_BITS'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// ----- sv/lr_front.sv -----
// ----------------------------------------------------------------------------
// lr_front
// accepts items, orders endpoints and computes the line setup values
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lr_front #(
    parameter int COORD_BITS = 11
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic                     i_mode,
    input  logic [COORD_BITS-1:0]    i_x_start,
    input  logic [COORD_BITS-1:0]    i_y_start,
    input  logic [COORD_BITS-1:0]    i_x_end,
    input  logic [COORD_BITS-1:0]    i_y_end,
    input  lr_pkg::t_fifo_stat       i_cmd_stat,
    output logic                     o_cmd_push,
    output logic                     o_mode,
    output logic [COORD_BITS-1:0]    o_origin_x,
    output logic [COORD_BITS-1:0]    o_origin_y,
    output logic                     o_mirror_x,
    output logic                     o_steep_line,
    output logic [COORD_BITS-1:0]    o_major_length,
    output logic [COORD_BITS+lr_pkg::DEC_EXTRA_BITS-1:0] o_decision,
    output logic [COORD_BITS+lr_pkg::DEC_EXTRA_BITS-1:0] o_east_inc,
    output logic [COORD_BITS+lr_pkg::DEC_EXTRA_BITS-1:0] o_ne_inc
);
    import lr_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int DW = COORD_BITS + DEC_EXTRA_BITS;

    // endpoint ordering, ahead of the register
    logic         swap;
    logic [W-1:0] lo_x, lo_y, hi_x, hi_y;
    logic [W:0]   dx;
    logic [W-1:0] dy;
    logic         take;

    logic         r_vld, n_vld;
    logic         r_mode;
    logic [W-1:0] r_ox, r_oy;
    logic [W:0]   r_dx;
    logic [W-1:0] r_dy;

    // octant classification, after the register
    logic          mirror;
    logic [W:0]    adx_full;
    logic [W-1:0]  adx;
    logic          steep;
    logic [W-1:0]  maj, mnr;
    logic [DW-1:0] twice_mnr, twice_maj;

    always_comb begin
        swap = (i_y_end < i_y_start);
        lo_x = swap ? i_x_end   : i_x_start;
        lo_y = swap ? i_y_end   : i_y_start;
        hi_x = swap ? i_x_start : i_x_end;
        hi_y = swap ? i_y_start : i_y_end;
        dx   = {1'b0, hi_x} - {1'b0, lo_x};
        dy   = hi_y - lo_y;
    end

    assign o_full     = r_vld && i_cmd_stat.full;
    assign take       = i_push && !o_full;
    assign o_cmd_push = r_vld && !i_cmd_stat.full;

    always_comb begin
        n_vld = take || (r_vld && !o_cmd_push);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_mode <= i_mode;
            r_ox   <= lo_x;
            r_oy   <= lo_y;
            r_dx   <= dx;
            r_dy   <= dy;
        end
    end

    always_comb begin
        mirror    = r_dx[W];
        adx_full  = mirror ? (~r_dx + 1'b1) : r_dx;
        adx       = adx_full[W-1:0];
        steep     = (r_dy > adx);
        maj       = steep ? r_dy : adx;
        mnr       = steep ? adx  : r_dy;
        twice_mnr = {{(DW-W-1){1'b0}}, mnr, 1'b0};
        twice_maj = {{(DW-W-1){1'b0}}, maj, 1'b0};
    end

    assign o_mode         = r_mode;
    assign o_origin_x     = r_ox;
    assign o_origin_y     = r_oy;
    assign o_mirror_x     = mirror;
    assign o_steep_line   = steep;
    assign o_major_length = maj;
    assign o_decision     = twice_mnr - {{(DW-W){1'b0}}, maj};
    assign o_east_inc     = twice_mnr;
    assign o_ne_inc       = twice_mnr - twice_maj;

endmodule

// ----- sv/lr_back.sv -----
// ----------------------------------------------------------------------------
// lr_back
// holds the active line and takes one midpoint step per advance item while a line is active
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lr_back #(
    parameter int COORD_BITS = 11
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  lr_pkg::t_fifo_stat       i_cmd_stat,
    output logic                     o_cmd_pop,
    input  logic                     i_mode,
    input  logic [COORD_BITS-1:0]    i_origin_x,
    input  logic [COORD_BITS-1:0]    i_origin_y,
    input  logic                     i_mirror_x,
    input  logic                     i_steep_line,
    input  logic [COORD_BITS-1:0]    i_major_length,
    input  logic [COORD_BITS+lr_pkg::DEC_EXTRA_BITS-1:0] i_decision,
    input  logic [COORD_BITS+lr_pkg::DEC_EXTRA_BITS-1:0] i_east_inc,
    input  logic [COORD_BITS+lr_pkg::DEC_EXTRA_BITS-1:0] i_ne_inc,
    input  lr_pkg::t_fifo_stat       i_out_stat,
    output logic                     o_out_push,
    output logic                     o_pixel_valid,
    output logic [COORD_BITS-1:0]    o_pixel_x,
    output logic [COORD_BITS-1:0]    o_pixel_y,
    output logic                     o_last_pixel
);
    import lr_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int DW = COORD_BITS + DEC_EXTRA_BITS;

    logic                 fire;

    logic                 r_active, n_active;
    logic signed [DW-1:0] r_dec, n_dec;
    logic signed [DW-1:0] r_east, n_east;
    logic signed [DW-1:0] r_ne, n_ne;
    logic [W-1:0]         r_px, n_px;
    logic [W-1:0]         r_py, n_py;
    logic [W-1:0]         r_remain, n_remain;
    logic                 r_mirror, n_mirror;
    logic                 r_steep, n_steep;

    logic                 step_ne;
    logic signed [DW-1:0] dec_step;
    logic                 x_move, y_move;
    logic [W-1:0]         px_step, py_step;
    logic                 last_step;

    assign fire       = !i_cmd_stat.empty && !i_out_stat.full;
    assign o_cmd_pop  = fire;
    assign o_out_push = fire;

    // one midpoint step from the current pixel
    always_comb begin
        step_ne   = (r_dec > 0);
        dec_step  = r_dec + (step_ne ? r_ne : r_east);
        x_move    = r_steep ? step_ne : 1'b1;
        y_move    = r_steep ? 1'b1 : step_ne;
        px_step   = r_px;
        if (x_move) begin
            px_step = r_mirror ? (r_px - 1'b1) : (r_px + 1'b1);
        end
        py_step   = y_move ? (r_py + 1'b1) : r_py;
        last_step = (r_remain == W'(1));
    end

    // result of the item at the queue head
    always_comb begin
        o_pixel_valid = 1'b0;
        o_pixel_x     = '0;
        o_pixel_y     = '0;
        o_last_pixel  = 1'b0;
        if (i_mode == MODE_START) begin
            o_pixel_valid = 1'b1;
            o_pixel_x     = i_origin_x;
            o_pixel_y     = i_origin_y;
            o_last_pixel  = (i_major_length == '0);
        end else if (r_active) begin
            o_pixel_valid = 1'b1;
            o_pixel_x     = px_step;
            o_pixel_y     = py_step;
            o_last_pixel  = last_step;
        end
    end

    always_comb begin
        n_active = r_active;
        n_dec    = r_dec;
        n_east   = r_east;
        n_ne     = r_ne;
        n_px     = r_px;
        n_py     = r_py;
        n_remain = r_remain;
        n_mirror = r_mirror;
        n_steep  = r_steep;
        if (fire) begin
            if (i_mode == MODE_START) begin
                n_active = (i_major_length != '0);
                n_dec    = $signed(i_decision);
                n_east   = $signed(i_east_inc);
                n_ne     = $signed(i_ne_inc);
                n_px     = i_origin_x;
                n_py     = i_origin_y;
                n_remain = i_major_length;
                n_mirror = i_mirror_x;
                n_steep  = i_steep_line;
            end else if (r_active) begin
                n_active = !last_step;
                n_dec    = dec_step;
                n_px     = px_step;
                n_py     = py_step;
                n_remain = r_remain - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec    <= n_dec;
        r_east   <= n_east;
        r_ne     <= n_ne;
        r_px     <= n_px;
        r_py     <= n_py;
        r_remain <= n_remain;
        r_mirror <= n_mirror;
        r_steep  <= n_steep;
    end

endmodule

// ----- sv/line_rasterizer_core.sv -----
// ----------------------------------------------------------------------------
// line_rasterizer_core
// path: front register, command queue, back stage, output queue, output ports
// throughput: one item and one pixel per cycle, as long as the two-entry queues
//   around the back stage neither fill up nor run dry
// reset: synchronous, active low; clears queues and the active line flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module line_rasterizer_core #(
    parameter int COORD_BITS = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic                  i_mode,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic                  o_pixel_valid,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last_pixel
);
    import lr_pkg::*;

    localparam int W     = COORD_BITS;
    localparam int DW    = COORD_BITS + DEC_EXTRA_BITS;
    localparam int CMD_W = 1 + 2 * W + 2 + W + 3 * DW;
    localparam int RES_W = 2 * W + 2;

    t_fifo_stat    cmd_stat, out_stat;
    logic          cmd_push, cmd_pop, out_push;
    logic [CMD_W-1:0] cmd_wr, cmd_rd;
    logic [RES_W-1:0] res_wr, res_rd;

    logic          f_mode, f_mirror, f_steep;
    logic [W-1:0]  f_ox, f_oy, f_len;
    logic [DW-1:0] f_dec, f_east, f_ne;

    logic          b_mode, b_mirror, b_steep;
    logic [W-1:0]  b_ox, b_oy, b_len;
    logic [DW-1:0] b_dec, b_east, b_ne;

    logic          r_valid, r_last;
    logic [W-1:0]  r_x, r_y;

    lr_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_mode         (i_mode),
        .i_x_start      (i_x_start),
        .i_y_start      (i_y_start),
        .i_x_end        (i_x_end),
        .i_y_end        (i_y_end),
        .i_cmd_stat     (cmd_stat),
        .o_cmd_push     (cmd_push),
        .o_mode         (f_mode),
        .o_origin_x     (f_ox),
        .o_origin_y     (f_oy),
        .o_mirror_x     (f_mirror),
        .o_steep_line   (f_steep),
        .o_major_length (f_len),
        .o_decision     (f_dec),
        .o_east_inc     (f_east),
        .o_ne_inc       (f_ne)
    );

    assign cmd_wr = {f_mode, f_ox, f_oy, f_mirror, f_steep, f_len, f_dec, f_east, f_ne};

    lr_fifo #(
        .WIDTH(CMD_W),
        .DEPTH(2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_wr),
        .i_pop   (cmd_pop),
        .o_data  (cmd_rd),
        .o_stat  (cmd_stat)
    );

    assign {b_mode, b_ox, b_oy, b_mirror, b_steep, b_len, b_dec, b_east, b_ne} = cmd_rd;

    lr_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_stat     (cmd_stat),
        .o_cmd_pop      (cmd_pop),
        .i_mode         (b_mode),
        .i_origin_x     (b_ox),
        .i_origin_y     (b_oy),
        .i_mirror_x     (b_mirror),
        .i_steep_line   (b_steep),
        .i_major_length (b_len),
        .i_decision     (b_dec),
        .i_east_inc     (b_east),
        .i_ne_inc       (b_ne),
        .i_out_stat     (out_stat),
        .o_out_push     (out_push),
        .o_pixel_valid  (r_valid),
        .o_pixel_x      (r_x),
        .o_pixel_y      (r_y),
        .o_last_pixel   (r_last)
    );

    assign res_wr = {r_valid, r_x, r_y, r_last};

    lr_fifo #(
        .WIDTH(RES_W),
        .DEPTH(2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (res_wr),
        .i_pop   (i_pop && !out_stat.empty),
        .o_data  (res_rd),
        .o_stat  (out_stat)
    );

    assign {o_pixel_valid, o_pixel_x, o_pixel_y, o_last_pixel} = res_rd;
    assign o_empty = out_stat.empty;

    // a result without a pixel carries no coordinates
    `ASSERT_IMPLY(a_idle_result_zero, i_clk, i_rst_n,
        !o_empty && !o_pixel_valid,
        o_pixel_x == '0 && o_pixel_y == '0 && !o_last_pixel)

    // the final pixel of a line is always a real pixel
    `ASSERT_IMPLY(a_last_is_valid, i_clk, i_rst_n,
        !o_empty && o_last_pixel, o_pixel_valid)

    // the back stage never writes a full output queue
    `ASSERT_IMPLY(a_no_out_overflow, i_clk, i_rst_n,
        out_push, !out_stat.full && !cmd_stat.empty)

    // reset leaves no result waiting
    `ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, o_empty)

endmodule
